[hw/rtl/swish_pkg.sv]
// shared constants and sigmoid knot table for the swish activation pipeline
`default_nettype none

package swish_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;

	// sigmoid values are Q0.16 with one extra bit so that 1.0 is exact
	localparam int SIG_W = 17;
	localparam logic [SIG_W-1:0] SIG_ONE = 17'h10000;

	// knots every 0.5 over [0, 16], index of a knot
	localparam int KNOT_COUNT = 33;
	localparam int SEG_W      = 6;

	function automatic logic [SIG_W-1:0] sig_knot(input logic [SEG_W-1:0] idx);
		logic [SIG_W-1:0] val;
		unique case (idx)
			6'd0:    val = 17'd32768;
			6'd1:    val = 17'd40794;
			6'd2:    val = 17'd47911;
			6'd3:    val = 17'd53581;
			6'd4:    val = 17'd57724;
			6'd5:    val = 17'd60565;
			6'd6:    val = 17'd62428;
			6'd7:    val = 17'd63615;
			6'd8:    val = 17'd64357;
			6'd9:    val = 17'd64816;
			6'd10:   val = 17'd65097;
			6'd11:   val = 17'd65269;
			6'd12:   val = 17'd65374;
			6'd13:   val = 17'd65438;
			6'd14:   val = 17'd65476;
			6'd15:   val = 17'd65500;
			6'd16:   val = 17'd65514;
			6'd17:   val = 17'd65523;
			6'd18:   val = 17'd65528;
			6'd19:   val = 17'd65531;
			6'd20:   val = 17'd65533;
			6'd21:   val = 17'd65534;
			6'd22:   val = 17'd65535;
			6'd23:   val = 17'd65535;
			default: val = SIG_ONE;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/swish_sigmoid.sv]
// three-stage piecewise linear sigmoid with x magnitude carried alongside
`default_nettype none

module swish_sigmoid #(
	parameter int DATA_WIDTH = swish_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = swish_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [FRAC_BITS+4:0]          zmag,
	input  wire logic                          zneg,
	input  wire logic [DATA_WIDTH-1:0]         xmag_in,
	input  wire logic                          xneg_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [swish_pkg::SIG_W-1:0]        sig,
	output logic [DATA_WIDTH-1:0]              xmag_out,
	output logic                               xneg_out
);
	import swish_pkg::*;

	localparam int ZW = FRAC_BITS + 5;
	localparam int FW = FRAC_BITS - 1;
	localparam int MW = SIG_W + FW;
	localparam logic [MW:0] RND_HALF = (MW+1)'(1) << (FRAC_BITS - 2);

	logic                  v_s4, v_s5, v_s6;
	logic                  en_s4, en_s5, en_s6;

	logic [SIG_W-1:0]      lo_s4, diff_s4;
	logic [FW-1:0]         frac_s4;
	logic                  zneg_s4;
	logic [DATA_WIDTH-1:0] xmag_s4;
	logic                  xneg_s4;

	logic [SIG_W-1:0]      lo_s5;
	logic [MW-1:0]         mul_s5;
	logic                  zneg_s5;
	logic [DATA_WIDTH-1:0] xmag_s5;
	logic                  xneg_s5;

	logic [SIG_W-1:0]      sig_s6;
	logic [DATA_WIDTH-1:0] xmag_s6;
	logic                  xneg_s6;

	logic [SEG_W-1:0]      seg;
	logic [SIG_W-1:0]      knot_lo, knot_hi;
	logic [MW:0]           step_sum;
	logic [SIG_W-1:0]      step, sig_pos;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// seg reaches the last knot only with a zero fraction, so hi past the end is harmless
	assign seg     = zmag[ZW-1:FW];
	assign knot_lo = sig_knot(seg);
	assign knot_hi = sig_knot(SEG_W'(seg + 1'b1));

	assign step_sum = (MW+1)'(mul_s5) + RND_HALF;
	assign step     = step_sum[FW +: SIG_W];
	assign sig_pos  = lo_s5 + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			lo_s4   <= knot_lo;
			diff_s4 <= knot_hi - knot_lo;
			frac_s4 <= zmag[FW-1:0];
			zneg_s4 <= zneg;
			xmag_s4 <= xmag_in;
			xneg_s4 <= xneg_in;
		end
		if (en_s5) begin
			lo_s5   <= lo_s4;
			mul_s5  <= MW'(diff_s4) * MW'(frac_s4);
			zneg_s5 <= zneg_s4;
			xmag_s5 <= xmag_s4;
			xneg_s5 <= xneg_s4;
		end
		if (en_s6) begin
			// negative z mirrors the positive half
			sig_s6  <= zneg_s5 ? (SIG_ONE - sig_pos) : sig_pos;
			xmag_s6 <= xmag_s5;
			xneg_s6 <= xneg_s5;
		end
	end

	assign out_valid = v_s6;
	assign sig       = sig_s6;
	assign xmag_out  = xmag_s6;
	assign xneg_out  = xneg_s6;

	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> sig_s6 <= SIG_ONE)
		else $error("sigmoid value above 1.0");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> seg <= SEG_W'(KNOT_COUNT - 1))
		else $error("sigmoid segment past last knot");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !out_ready |=> v_s6 && $stable(sig_s6))
		else $error("sigmoid result changed while stalled");

endmodule

`default_nettype wire

[hw/rtl/swish_activation.sv]
// swish activation top level: y = x * sigmoid(alpha * x), Q4.12 in and out
// a transaction passes stages s1 to s3, the sigmoid's s4 to s6, then s7 and s8, in order
// throughput: one transaction per cycle while the output is not stalled; every stage advances when its successor frees
// a stall at the output backs up stage by stage, bubbles are squeezed out first
// reset clears all stage valid bits and sets alpha_q to 1.0
`default_nettype none

module swish_activation #(
	parameter int DATA_WIDTH = swish_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = swish_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic signed [DATA_WIDTH-1:0] cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [DATA_WIDTH-1:0] sample_in,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      sample_out
);
	import swish_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int ZW = FRAC_BITS + 5;
	localparam int PW = 2 * DW;
	localparam int CW = (PW + 1 > FRAC_BITS + 6) ? PW + 1 : FRAC_BITS + 6;
	localparam int YW = DW + SIG_W;
	localparam int RW = YW + 1;
	localparam logic [CW-1:0] HALF_Z = CW'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0] ZLIM   = CW'(16) << FRAC_BITS;
	localparam logic [RW-1:0] HALF_Y = RW'(1) << 15;
	localparam logic [DW+1:0] LIM_N  = (DW+2)'(1) << (DW - 1);
	localparam logic [DW+1:0] LIM_P  = LIM_N - 1'b1;

	logic [DW-1:0]   alpha_q;

	logic            v_s1, v_s2, v_s3, v_s7, v_s8;
	logic            en_s1, en_s2, en_s3, en_s7, en_s8;

	logic [DW-1:0]   xmag_s1, amag_s1;
	logic            xneg_s1, aneg_s1;
	logic [PW-1:0]   prod_s2;
	logic [DW-1:0]   xmag_s2, xmag_s3;
	logic            xneg_s2, zneg_s2, xneg_s3, zneg_s3;
	logic [ZW-1:0]   zmag_s3;
	logic [YW-1:0]   yprod_s7;
	logic            xneg_s7;
	logic [DW-1:0]   y_s8;
	logic            xneg_s8;

	logic            sig_in_ready, sig_valid;
	logic [SIG_W-1:0] sig;
	logic [DW-1:0]   xmag_sig;
	logic            xneg_sig;

	logic [DW-1:0]   xraw, araw, xmag, amag;
	logic [CW-1:0]   zsum, zround;
	logic [ZW-1:0]   zsat;
	logic [RW-1:0]   ysum;
	logic [DW+1:0]   ymag, yclip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= DW'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	assign en_s8    = !v_s8 || out_ready;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s3    = !v_s3 || sig_in_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// sign and magnitude split
	assign xraw = sample_in;
	assign araw = alpha_q;
	assign xmag = xraw[DW-1] ? (~xraw + 1'b1) : xraw;
	assign amag = araw[DW-1] ? (~araw + 1'b1) : araw;

	// z rounded half away from zero on the magnitude, clamped at 16.0
	assign zsum   = CW'(prod_s2) + HALF_Z;
	assign zround = zsum >> FRAC_BITS;
	assign zsat   = (zround > ZLIM) ? ZW'(ZLIM) : zround[ZW-1:0];

	// y magnitude rounded at the Q0.16 point, clamped per sign
	assign ysum  = RW'(yprod_s7) + HALF_Y;
	assign ymag  = ysum[16 +: DW+2];
	assign yclip = xneg_s7 ? ((ymag > LIM_N) ? LIM_N : ymag)
	                       : ((ymag > LIM_P) ? LIM_P : ymag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s7) v_s7 <= sig_valid;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			xmag_s1 <= xmag;
			xneg_s1 <= xraw[DW-1];
			amag_s1 <= amag;
			aneg_s1 <= araw[DW-1];
		end
		if (en_s2) begin
			prod_s2 <= PW'(xmag_s1) * PW'(amag_s1);
			xmag_s2 <= xmag_s1;
			xneg_s2 <= xneg_s1;
			zneg_s2 <= xneg_s1 ^ aneg_s1;
		end
		if (en_s3) begin
			zmag_s3 <= zsat;
			zneg_s3 <= zneg_s2 && (zsat != '0);
			xmag_s3 <= xmag_s2;
			xneg_s3 <= xneg_s2;
		end
		if (en_s7) begin
			yprod_s7 <= YW'(xmag_sig) * YW'(sig);
			xneg_s7  <= xneg_sig;
		end
		if (en_s8) begin
			y_s8    <= xneg_s7 ? DW'(~yclip + 1'b1) : yclip[DW-1:0];
			xneg_s8 <= xneg_s7;
		end
	end

	swish_sigmoid #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_sigmoid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (sig_in_ready),
		.zmag     (zmag_s3),
		.zneg     (zneg_s3),
		.xmag_in  (xmag_s3),
		.xneg_in  (xneg_s3),
		.out_valid(sig_valid),
		.out_ready(en_s7),
		.sig      (sig),
		.xmag_out (xmag_sig),
		.xneg_out (xneg_sig)
	);

	assign out_valid  = v_s8;
	assign sample_out = y_s8;

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("pipeline refused a transaction with output free");

	a_zmag_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> CW'(zmag_s3) <= ZLIM)
		else $error("z magnitude above clamp");

	a_out_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !xneg_s8 |-> !y_s8[DW-1])
		else $error("nonnegative sample gave negative result");

endmodule

`default_nettype wire

[tb/sv/swish_activation_test.sv]
// self-checking testbench for the swish activation pipeline
`default_nettype none

module swish_activation_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = swish_pkg::DATA_WIDTH_DEF;
	localparam int FB = swish_pkg::FRAC_BITS_DEF;
	localparam int KNOTS = swish_pkg::KNOT_COUNT;
	localparam longint SIG_UNITY = swish_pkg::SIG_ONE;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 64;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_SHOWN = 10;
	localparam int IDLE_PCT = 37;

	// sigmoid(k/2) in Q0.16 for k = 0..32
	localparam longint KNOT_Q16 [KNOTS] = '{
		32768, 40794, 47911, 53581, 57724, 60565, 62428, 63615,
		64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
		65514, 65523, 65528, 65531, 65533, 65534, 65535, 65535,
		65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536,
		65536
	};

	typedef logic signed [DW-1:0] sample_t;
	typedef struct {
		sample_t x;
		sample_t y;
	} silu_pair_t;
	typedef struct {
		bit      load_alpha;
		sample_t alpha;
		sample_t x;
		bit      known;
		sample_t y;
	} vector_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_we = 1'b0;
	sample_t cfg_wdata = '0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t sample_in = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t sample_out;

	silu_pair_t  pending_out[$];
	vector_row_t vectors[$];
	sample_t     alpha_now;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = IDLE_PCT;
	int          rx_idle_pct = IDLE_PCT;
	int          hold_asks = 0;
	int          hold_served = 0;
	int          hold_left = 0;

	swish_activation uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[swish_activation] ERROR");
			$finish;
		end
	end

	// x * sigmoid(alpha * x) in sign-magnitude, rounded half away from zero
	function automatic sample_t silu_of(input sample_t x, input sample_t a);
		longint xv, av, xm, am, z, seg, frac, lo, hi, sig, y;
		bit zneg;
		xv = x;
		av = a;
		xm = (xv < 0) ? -xv : xv;
		am = (av < 0) ? -av : av;
		z = (xm * am + (64'sd1 << (FB - 1))) >> FB;
		if (z > (64'sd16 << FB))
			z = 64'sd16 << FB;
		zneg = ((xv < 0) != (av < 0)) && (z != 0);
		seg = z >> (FB - 1);
		frac = z & ((64'sd1 << (FB - 1)) - 1);
		if (seg >= KNOTS - 1) begin
			sig = KNOT_Q16[KNOTS-1];
		end else begin
			lo = KNOT_Q16[seg];
			hi = KNOT_Q16[seg+1];
			sig = lo + (((hi - lo) * frac + (64'sd1 << (FB - 2))) >> (FB - 1));
		end
		// negative half by symmetry
		if (zneg)
			sig = SIG_UNITY - sig;
		y = (xm * sig + 32768) >> 16;
		if (xv < 0) begin
			if (y > (64'sd1 << (DW - 1)))
				y = 64'sd1 << (DW - 1);
			return DW'(-y);
		end
		if (y > (64'sd1 << (DW - 1)) - 1)
			y = (64'sd1 << (DW - 1)) - 1;
		return DW'(y);
	endfunction

	function automatic sample_t rand_sample();
		int v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return sample_t'(32767);
					1: return sample_t'(-32768);
					2: return sample_t'(0);
					3: return sample_t'(1);
					default: return sample_t'(-1);
				endcase
			end
			1, 2, 3: begin
				v = $urandom_range(0, 8191);
				return $urandom_range(1) ? sample_t'(-v) : sample_t'(v);
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic offer_sample(input sample_t x, input sample_t y);
		int gap;
		gap = 0;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		pending_out.push_back('{x: x, y: y});
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_alpha(input sample_t a);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(negedge clk);
		cfg_we <= 1'b0;
		alpha_now = a;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		silu_pair_t head;
		if (arst_n && out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected transaction: sample_out=%0d", sample_out);
			end else begin
				head = pending_out.pop_front();
				if (sample_out !== head.y) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: x=%0d alpha=%0d expected %0d got %0d",
							head.x, alpha_now, head.y, sample_out);
				end
			end
		end
	end

	initial begin
		sample_t x;
		sample_t a;
		alpha_now = sample_t'(1 << FB);

		// reset alpha is 1.0
		vectors.push_back('{0, 0, 0, 1, 0});
		vectors.push_back('{0, 0, 1, 1, 1});
		vectors.push_back('{0, 0, -1, 1, 0});
		vectors.push_back('{0, 0, 32767, 0, 0});
		vectors.push_back('{0, 0, -32768, 0, 0});
		vectors.push_back('{0, 0, 4096, 0, 0});
		vectors.push_back('{0, 0, -4096, 0, 0});
		vectors.push_back('{0, 0, 2048, 0, 0});
		// zero gain: sigmoid is one half
		vectors.push_back('{1, 0, 32767, 1, 16384});
		vectors.push_back('{0, 0, -32768, 1, -16384});
		vectors.push_back('{0, 0, 3, 1, 2});
		vectors.push_back('{0, 0, -3, 1, -2});
		vectors.push_back('{0, 0, 0, 1, 0});
		// largest gain: product saturates at 16
		vectors.push_back('{1, 32767, 32767, 1, 32767});
		vectors.push_back('{0, 0, -32768, 1, 0});
		vectors.push_back('{0, 0, 16384, 1, 16384});
		vectors.push_back('{0, 0, 1, 0, 0});
		// most negative gain
		vectors.push_back('{1, -32768, 32767, 1, 0});
		vectors.push_back('{0, 0, -32768, 1, -32768});
		vectors.push_back('{0, 0, 1, 0, 0});
		vectors.push_back('{0, 0, -12345, 0, 0});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (vectors[i]) begin
			if (vectors[i].load_alpha)
				write_alpha(vectors[i].alpha);
			offer_sample(vectors[i].x,
				vectors[i].known ? vectors[i].y : silu_of(vectors[i].x, alpha_now));
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: a = sample_t'(1 << FB);
				2: a = sample_t'($urandom_range(0, 8191));
				3: a = sample_t'(-$urandom_range(1, 16384));
				5: a = sample_t'($urandom_range(0, 2));
				default: a = sample_t'($urandom);
			endcase
			write_alpha(a);
			// phase 1 runs with no idling on either side
			tx_idle_pct = (p == 1 || p == 2) ? 0 : IDLE_PCT;
			rx_idle_pct <= (p == 1) ? 0 : IDLE_PCT;
			// phase 2: receiver holds off while the sender streams, filling the pipe
			if (p == 2)
				hold_asks <= hold_asks + 1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (p == 3 && k == ITEMS_PER_PHASE / 2)
					drain_results();
				x = rand_sample();
				offer_sample(x, silu_of(x, alpha_now));
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_out.size() == 0)
			$display("[swish_activation] OK");
		else
			$display("[swish_activation] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
